/* rtl/core/fbfl_pkg.sv */
// Shared types and constants for the fixed-size block pool allocator.
// No dependencies; used by fbfl_ctrl, fbfl_datapath and the top level.
package fbfl_pkg;

   // Pool geometry, fixed by the item field widths
   localparam int MAX_BLOCKS = 256;
   localparam int IDX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int WORDS_W    = 15;
   localparam int OFFSET_W   = 24;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_WORDS   = 2'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic start;   // item accepted this cycle
      logic finish;  // link read data is back, complete the alloc
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_lookup;  // presented item is an alloc that pops the list
      logic rsp_hold;     // result register full and not taken this cycle
   } dp_stat_type;

endpackage

/* rtl/core/fbfl_ctrl.sv */
// Controller state machine for the block pool allocator.
// Depends on fbfl_pkg for the command and status structs.
module fbfl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  fbfl_pkg::dp_stat_type stat,
   output fbfl_pkg::dp_cmd_type  cmd
);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_LOOKUP = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // Take an item only when idle and the result register has room
   assign req_tready = (state_ff == S_IDLE) && !stat.rsp_hold;
   assign accept     = req_tvalid && req_tready;

   assign cmd.start  = accept;
   assign cmd.finish = (state_ff == S_LOOKUP);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && stat.need_lookup) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/fbfl_datapath.sv */
// Datapath for the block pool allocator: registers, link memory with
// per-block valid bits, offset multiplier and result register. Uses fbfl_pkg.
module fbfl_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [fbfl_pkg::OP_W-1:0]              req_op,
   input  logic [fbfl_pkg::IDX_W-1:0]             req_block_index,
   input  logic                                   csr_write,
   input  logic [fbfl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fbfl_pkg::WORDS_W-1:0]           csr_wdata,
   input  fbfl_pkg::dp_cmd_type                    cmd,
   output fbfl_pkg::dp_stat_type                   stat,
   input  logic                                   rsp_tready,
   output logic                                   rsp_valid,
   output logic [fbfl_pkg::STATUS_W-1:0]          rsp_status,
   output logic [fbfl_pkg::IDX_W-1:0]             rsp_granted_index,
   output logic [fbfl_pkg::OFFSET_W-1:0]          rsp_byte_offset,
   output logic [fbfl_pkg::CNT_W-1:0]             rsp_free_blocks,
   output logic [fbfl_pkg::CNT_W-1:0]             rsp_used_blocks
);

   localparam int IW = fbfl_pkg::IDX_W;
   localparam int CW = fbfl_pkg::CNT_W;
   localparam int WW = fbfl_pkg::WORDS_W;
   localparam int PW = IW + WW;
   localparam logic [CW-1:0] MAX_CNT = CW'(fbfl_pkg::MAX_BLOCKS);

   // Configuration registers
   logic [CW-1:0] blocks_ff;
   logic [WW-1:0] words_ff;

   // List state
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] free_ff, free_in;
   logic [fbfl_pkg::MAX_BLOCKS-1:0] valid_ff, valid_in;

   // Link memory and its registered read
   logic [IW-1:0] link_mem [fbfl_pkg::MAX_BLOCKS];
   logic [IW-1:0] rd_ff;
   logic          rd_valid_ff;
   logic [IW-1:0] pop_ff;
   logic          mem_we;
   logic          mem_re;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fbfl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [IW-1:0]                granted_ff, granted_in;
   logic [fbfl_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [CW-1:0]                free_out_ff;
   logic [CW-1:0]                used_ff, used_in;
   logic                         load;

   logic [CW-1:0] pool_n;
   logic [PW-1:0] prod;
   logic [IW-1:0] next_head;
   logic          free_ok;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= MAX_CNT;
         words_ff  <= WW'(1);
      end else if (csr_write) begin
         if (csr_index == fbfl_pkg::REG_BLOCKS_IN_USE) begin
            blocks_ff <= csr_wdata[CW-1:0];
         end else if (csr_index == fbfl_pkg::REG_BLOCK_WORDS) begin
            words_ff <= csr_wdata;
         end
      end
   end

   // Effective pool size: zero reads as one, oversize clamps to the maximum
   always_comb begin
      if (blocks_ff == '0) begin
         pool_n = CW'(1);
      end else if (blocks_ff > MAX_CNT) begin
         pool_n = MAX_CNT;
      end else begin
         pool_n = blocks_ff;
      end
   end

   assign stat.need_lookup = (req_op == fbfl_pkg::OP_ALLOC) && (free_ff != '0);
   assign stat.rsp_hold    = rsp_valid_ff && !rsp_tready;

   assign free_ok = ({1'b0, req_block_index} < pool_n) && (free_ff < pool_n);

   // A link not written since the last init reads as the next block
   assign next_head = rd_valid_ff ? rd_ff : pop_ff + IW'(1);

   // Offset = index * words * 4, low bits kept
   assign prod      = PW'(pop_ff) * PW'(words_ff);

   assign mem_we = cmd.start && (req_op == fbfl_pkg::OP_FREE) && free_ok;
   assign mem_re = cmd.start && stat.need_lookup;

   // List update and result formation
   always_comb begin
      head_in    = head_ff;
      free_in    = free_ff;
      valid_in   = valid_ff;
      status_in  = fbfl_pkg::ST_OK;
      granted_in = '0;
      offset_in  = '0;
      load       = 1'b0;
      if (cmd.finish) begin
         head_in    = next_head;
         free_in    = free_ff - CW'(1);
         granted_in = pop_ff;
         offset_in  = {prod[fbfl_pkg::OFFSET_W-3:0], 2'b00};
         load       = 1'b1;
      end else if (cmd.start && !stat.need_lookup) begin
         load = 1'b1;
         unique case (req_op)
            fbfl_pkg::OP_INIT: begin
               head_in  = '0;
               free_in  = pool_n;
               valid_in = '0;
            end
            fbfl_pkg::OP_ALLOC: begin
               status_in = fbfl_pkg::ST_EMPTY;
            end
            fbfl_pkg::OP_FREE: begin
               if (free_ok) begin
                  head_in                   = req_block_index;
                  free_in                   = free_ff + CW'(1);
                  valid_in[req_block_index] = 1'b1;
               end else begin
                  status_in = fbfl_pkg::ST_BAD_FREE;
               end
            end
            default: begin
            end
         endcase
      end
      used_in = (pool_n > free_in) ? (pool_n - free_in) : '0;
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         free_ff      <= MAX_CNT;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Link memory: push writes, pop reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[req_block_index] <= head_ff;
      end
      if (mem_re) begin
         rd_ff       <= link_mem[head_ff];
         rd_valid_ff <= valid_ff[head_ff];
         pop_ff      <= head_ff;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= status_in;
         granted_ff  <= granted_in;
         offset_ff   <= offset_in;
         free_out_ff <= free_in;
         used_ff     <= used_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_free_blocks   = free_out_ff;
   assign rsp_used_blocks   = used_ff;

endmodule

/* rtl/core/fixed_block_free_list_allocator.sv */
// Fixed-size block pool allocator, LIFO free list. Init, free, an unused op
// code and an alloc on an empty pool each load the result directly; an
// alloc that pops a block waits for the registered link memory read. The
// result sits in an output register, and the next item is taken once that
// register is empty or being taken in the same cycle. Init relinks the whole
// pool at once by clearing one valid bit per block; an unwritten link reads
// as the next block index.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_datapath.
module fixed_block_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: op[1:0], block_index[9:2], zero fill [15:10]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: status[1:0], granted_index[9:2], byte_offset[33:10],
   //            free_blocks[42:34], used_blocks[51:43], zero fill [55:52]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [fbfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbfl_pkg::WORDS_W-1:0]   csr_wdata
);

   fbfl_pkg::dp_cmd_type  cmd;
   fbfl_pkg::dp_stat_type stat;

   logic [fbfl_pkg::STATUS_W-1:0] rsp_status;
   logic [fbfl_pkg::IDX_W-1:0]    rsp_granted_index;
   logic [fbfl_pkg::OFFSET_W-1:0] rsp_byte_offset;
   logic [fbfl_pkg::CNT_W-1:0]    rsp_free_blocks;
   logic [fbfl_pkg::CNT_W-1:0]    rsp_used_blocks;

   // Registers are always writable
   assign csr_ready = 1'b1;

   fbfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fbfl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_tdata[1:0]),
      .req_block_index   (req_tdata[9:2]),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_free_blocks   (rsp_free_blocks),
      .rsp_used_blocks   (rsp_used_blocks)
   );

   // Result packing, lowest field first
   assign rsp_tdata = {4'b0000, rsp_used_blocks, rsp_free_blocks, rsp_byte_offset,
                       rsp_granted_index, rsp_status};

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for fixed_block_free_list_allocator: directed and random
// init, alloc and free items under random stalls, checked against a pool model.
// Depends on fbfl_pkg and the allocator RTL only.
module tb_top;
   import fbfl_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 1950;
   localparam int HOLD_CYCLES  = 200;
   localparam int QUIET_LIMIT  = 1000;
   localparam int SETTLE_CYCLES = 4;

   // Pool state: link per block, head of the free list, free count
   typedef struct packed {
      logic [MAX_BLOCKS-1:0][IDX_W-1:0] link;
      logic [IDX_W-1:0]                 head;
      logic [CNT_W-1:0]                 free_cnt;
   } pool_state_t;

   // One result, laid out as rsp_tdata[51:0]
   typedef struct packed {
      logic [CNT_W-1:0]    used_cnt;
      logic [CNT_W-1:0]    free_cnt;
      logic [OFFSET_W-1:0] offset;
      logic [IDX_W-1:0]    granted;
      logic [STATUS_W-1:0] status;
   } alloc_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORDS_W-1:0]   csr_wdata = '0;

   // Register copies shared by both pool models
   logic [CNT_W-1:0]   cfg_blocks = 9'd256;
   logic [WORDS_W-1:0] cfg_words  = 15'd1;

   pool_state_t   gen_pool;      // runs ahead while items are generated
   pool_state_t   pred_pool;     // advances on each accepted item
   int            held_q[$];     // blocks the generator believes are allocated
   logic [15:0]   pending_reqs[$];
   alloc_result_t expected_replies[$];
   alloc_result_t got_reply;
   alloc_result_t want_reply;
   alloc_result_t new_reply;

   int   items_queued = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   hold_asked = 0;
   int   hold_done = 0;
   int   hold_left = 0;
   logic calm_phase = 1'b0;
   logic req_taken = 1'b0;

   fixed_block_free_list_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Pool size as the block sees it: zero reads as one, clipped to MAX_BLOCKS
   function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v);
      if (v == '0) return 9'd1;
      if (v > 9'(MAX_BLOCKS)) return 9'(MAX_BLOCKS);
      return v;
   endfunction

   function automatic void pool_relink(inout pool_state_t st);
      for (int i = 0; i < MAX_BLOCKS; i++) st.link[i] = 8'(i + 1);
      st.head     = '0;
      st.free_cnt = eff_size(cfg_blocks);
   endfunction

   // Advance a pool by one item and work out its result
   function automatic void pool_apply(inout pool_state_t st, input logic [OP_W-1:0] op,
                                      input logic [IDX_W-1:0] idx,
                                      output alloc_result_t res);
      logic [CNT_W-1:0] n;
      logic [47:0]      prod;
      n   = eff_size(cfg_blocks);
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_INIT: pool_relink(st);
         OP_ALLOC: begin
            if (st.free_cnt == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.granted = st.head;
               prod        = 48'(st.head) * 48'(cfg_words);
               res.offset  = {prod[21:0], 2'b00};
               st.head     = st.link[st.head];
               st.free_cnt = st.free_cnt - 9'd1;
            end
         end
         OP_FREE: begin
            if (9'(idx) >= n || st.free_cnt >= n) begin
               res.status = ST_BAD_FREE;
            end else begin
               st.link[idx] = st.head;
               st.head      = idx;
               st.free_cnt  = st.free_cnt + 9'd1;
            end
         end
         default: ;
      endcase
      res.free_cnt = st.free_cnt;
      res.used_cnt = (n > st.free_cnt) ? n - st.free_cnt : '0;
   endfunction

   // Queue one item and keep the generator's view of allocated blocks
   function automatic void put_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
      alloc_result_t r;
      pool_apply(gen_pool, op, idx, r);
      if (op == OP_INIT) begin
         held_q.delete();
      end else if (op == OP_ALLOC && r.status == ST_OK) begin
         held_q.push_back(int'(r.granted));
      end else if (op == OP_FREE && r.status == ST_OK) begin
         for (int k = 0; k < held_q.size(); k++) begin
            if (held_q[k] == int'(idx)) begin
               held_q.delete(k);
               break;
            end
         end
      end
      pending_reqs.push_back({6'd0, idx, op});
      items_queued++;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Register write; both pool models pick up the new value
   task automatic csr_write(input logic [CSR_IDX_W-1:0] ri, input logic [WORDS_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= ri;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (ri == REG_BLOCKS_IN_USE) begin
         cfg_blocks = val[CNT_W-1:0];
      end else begin
         cfg_words = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every item is in and every result is out, then let it settle
   task automatic wait_idle();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: next item once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && (calm_phase || $urandom_range(99) >= 11)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_reqs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= hold_asked;
      end else begin
         rsp_tready <= calm_phase || ($urandom_range(99) >= 11);
      end
   end

   // Monitor: check results, predict on accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_reply = alloc_result_t'(rsp_tdata[51:0]);
            if (expected_replies.size() == 0) begin
               $error("result with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want_reply = expected_replies.pop_front();
               check_field("status", want_reply.status, got_reply.status);
               check_field("granted_index", want_reply.granted, got_reply.granted);
               check_field("byte_offset", want_reply.offset, got_reply.offset);
               check_field("free_blocks", want_reply.free_cnt, got_reply.free_cnt);
               check_field("used_blocks", want_reply.used_cnt, got_reply.used_cnt);
            end
         end
         if (req_tvalid && req_tready) begin
            pool_apply(pred_pool, req_tdata[1:0], req_tdata[9:2], new_reply);
            expected_replies.push_back(new_reply);
         end
      end
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               phase;
      int               len;
      int               alloc_pct;
      int               r;
      logic [CNT_W-1:0] blk;
      logic [WORDS_W-1:0] wrd;
      logic [IDX_W-1:0] rnd_idx;

      pool_relink(gen_pool);
      pool_relink(pred_pool);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: pops along the chain, pushes, full pool, unused op
      put_item(OP_ALLOC, 8'hFF);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_FREE, 8'd1);
      put_item(OP_FREE, 8'd0);
      put_item(OP_FREE, 8'd0);
      put_item(OP_UNUSED, 8'hFF);
      put_item(OP_INIT, 8'hAA);
      wait_idle();

      // Zero pool size reads as one; shrink first without init
      csr_write(REG_BLOCKS_IN_USE, 15'd0);
      csr_write(REG_BLOCK_WORDS, 15'd16384);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_INIT, 8'h00);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_FREE, 8'd1);
      put_item(OP_FREE, 8'd0);
      put_item(OP_FREE, 8'd0);
      wait_idle();

      // Oversized pool clips to MAX_BLOCKS; largest words wrap the offset
      csr_write(REG_BLOCKS_IN_USE, 15'd300);
      csr_write(REG_BLOCK_WORDS, 15'h7FFF);
      put_item(OP_INIT, 8'h55);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_FREE, 8'd255);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_FREE, 8'd0);
      wait_idle();

      // Zero words gives a zero offset
      csr_write(REG_BLOCKS_IN_USE, 15'd511);
      csr_write(REG_BLOCK_WORDS, 15'd0);
      put_item(OP_ALLOC, 8'h00);
      put_item(OP_FREE, 8'd128);

      // Random phases, each with its own pool geometry and alloc bias
      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(5))
            0:       blk = 9'd1;
            1:       blk = 9'd256;
            2:       blk = 9'($urandom_range(511));
            default: blk = 9'($urandom_range(24, 1));
         endcase
         case ($urandom_range(5))
            0:       wrd = 15'd0;
            1:       wrd = 15'd1;
            2:       wrd = 15'd16384;
            3:       wrd = 15'h7FFF;
            default: wrd = 15'($urandom);
         endcase
         csr_write(REG_BLOCKS_IN_USE, 15'(blk));
         csr_write(REG_BLOCK_WORDS, wrd);
         @(posedge clock);
         calm_phase = (phase % 5 == 2);
         if ($urandom_range(9) != 0) put_item(OP_INIT, 8'($urandom));
         alloc_pct = $urandom_range(75, 30);
         len = $urandom_range(160, 40);
         repeat (len) begin
            r = $urandom_range(99);
            rnd_idx = 8'($urandom);
            if (r < 3) begin
               put_item(OP_INIT, rnd_idx);
            end else if (r < 6) begin
               put_item(OP_UNUSED, rnd_idx);
            end else if (r < 12) begin
               put_item(OP_FREE, rnd_idx);
            end else if (held_q.size() == 0 || $urandom_range(99) < alloc_pct) begin
               put_item(OP_ALLOC, rnd_idx);
            end else begin
               put_item(OP_FREE, 8'(held_q[$urandom_range(held_q.size() - 1)]));
            end
         end
         // long receiver hold-off while the sender keeps offering items
         if (phase == 1) hold_asked = hold_asked + 1;
         phase++;
      end
      wait_idle();

      if (expected_replies.size() != 0) begin
         $error("%0d results never arrived", expected_replies.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
